>>> rtl/rbsi_pkg.sv
// Shared types and constants for the ray / box slab test pipeline.
package rbsi_pkg;

   localparam int NUM_AXES    = 3;
   localparam int NUM_REGS    = 8;
   localparam int PIPE_STAGES = 6;

   // Configuration register indexes, in address order.
   typedef enum logic [2:0] {
      CSR_ORIGIN_X,
      CSR_ORIGIN_Y,
      CSR_ORIGIN_Z,
      CSR_INV_DIR_X,
      CSR_INV_DIR_Y,
      CSR_INV_DIR_Z,
      CSR_WINDOW_LOW,
      CSR_WINDOW_HIGH
   } csr_index_type;

   // Load enables for the four per-axis stages.
   typedef struct packed {
      logic diff;
      logic mul;
      logic prod;
      logic sort;
   } axis_adv_type;

endpackage

>>> rtl/rbsi_csr.sv
// APB register file holding the ray origin, reciprocal direction and window.
module rbsi_csr import rbsi_pkg::*; #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16,
   parameter int DATA_BITS  = 32,
   parameter int ADDR_BITS  = 5
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [ADDR_BITS-1:0]         csr_paddr,
   input  logic [DATA_BITS-1:0]         csr_pwdata,
   output logic [DATA_BITS-1:0]         csr_prdata,
   output logic                         csr_pready,
   output logic signed [COORD_BITS-1:0] origin [NUM_AXES],
   output logic signed [COORD_BITS-1:0] inv_dir [NUM_AXES],
   output logic signed [COORD_BITS-1:0] window_low,
   output logic signed [COORD_BITS-1:0] window_high
);

   localparam int IDX_LSB = ADDR_BITS - 3;
   localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam logic [COORD_BITS-1:0] COORD_MAX = ~COORD_MIN;
   localparam logic [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(1) << FRAC_BITS;

   logic [COORD_BITS-1:0] regs_ff [NUM_REGS];
   csr_index_type         idx;
   logic                  wr_en;

   assign idx        = csr_index_type'(csr_paddr[ADDR_BITS-1:IDX_LSB]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = DATA_BITS'(regs_ff[idx]);

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff[CSR_ORIGIN_X]    <= '0;
         regs_ff[CSR_ORIGIN_Y]    <= '0;
         regs_ff[CSR_ORIGIN_Z]    <= '0;
         regs_ff[CSR_INV_DIR_X]   <= COORD_ONE;
         regs_ff[CSR_INV_DIR_Y]   <= COORD_ONE;
         regs_ff[CSR_INV_DIR_Z]   <= COORD_ONE;
         regs_ff[CSR_WINDOW_LOW]  <= COORD_MIN;
         regs_ff[CSR_WINDOW_HIGH] <= COORD_MAX;
      end else if (wr_en) begin
         regs_ff[idx] <= csr_pwdata[COORD_BITS-1:0];
      end
   end

   assign origin[0]   = $signed(regs_ff[CSR_ORIGIN_X]);
   assign origin[1]   = $signed(regs_ff[CSR_ORIGIN_Y]);
   assign origin[2]   = $signed(regs_ff[CSR_ORIGIN_Z]);
   assign inv_dir[0]  = $signed(regs_ff[CSR_INV_DIR_X]);
   assign inv_dir[1]  = $signed(regs_ff[CSR_INV_DIR_Y]);
   assign inv_dir[2]  = $signed(regs_ff[CSR_INV_DIR_Z]);
   assign window_low  = $signed(regs_ff[CSR_WINDOW_LOW]);
   assign window_high = $signed(regs_ff[CSR_WINDOW_HIGH]);

endmodule

>>> rtl/rbsi_axis.sv
// One axis of the slab test: offset, split multiply, shift/saturate, sort.
module rbsi_axis import rbsi_pkg::*; #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  axis_adv_type                 adv,
   input  logic signed [COORD_BITS-1:0] box_min,
   input  logic signed [COORD_BITS-1:0] box_max,
   input  logic signed [COORD_BITS-1:0] origin,
   input  logic signed [COORD_BITS-1:0] inv_dir,
   output logic signed [COORD_BITS-1:0] t_lo,
   output logic signed [COORD_BITS-1:0] t_hi
);

   localparam int DW  = COORD_BITS + 1;        // exact difference
   localparam int LB  = COORD_BITS / 2;        // low slice of inv_dir, unsigned
   localparam int HB  = COORD_BITS - LB;       // high slice, signed
   localparam int PW  = 2 * COORD_BITS + 1;    // full product
   localparam int SW  = PW - FRAC_BITS;        // product after the shift
   localparam logic signed [COORD_BITS-1:0] COORD_MIN =
      {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MAX = ~COORD_MIN;

   // floor(p / 2^FRAC_BITS), clamped to the coordinate range
   function automatic logic signed [COORD_BITS-1:0] shift_sat(
      input logic signed [PW-1:0] p);
      logic [SW-1:0]           s;
      logic [SW-COORD_BITS:0]  top;
      s   = p[PW-1:FRAC_BITS];
      top = s[SW-1:COORD_BITS-1];
      if (top == '0 || top == '1) begin
         shift_sat = $signed(s[COORD_BITS-1:0]);
      end else if (s[SW-1]) begin
         shift_sat = COORD_MIN;
      end else begin
         shift_sat = COORD_MAX;
      end
   endfunction

   logic signed [DW-1:0]      dmin_ff, dmax_ff;
   logic signed [DW+LB:0]     pmin_lo_ff, pmax_lo_ff, pmin_lo_in, pmax_lo_in;
   logic signed [DW+HB-1:0]   pmin_hi_ff, pmax_hi_ff, pmin_hi_in, pmax_hi_in;
   logic signed [PW-1:0]      prod_min, prod_max;
   logic signed [COORD_BITS-1:0] t1_ff, t2_ff, lo_ff, hi_ff;

   assign pmin_lo_in = dmin_ff * $signed({1'b0, inv_dir[LB-1:0]});
   assign pmax_lo_in = dmax_ff * $signed({1'b0, inv_dir[LB-1:0]});
   assign pmin_hi_in = dmin_ff * $signed(inv_dir[COORD_BITS-1:LB]);
   assign pmax_hi_in = dmax_ff * $signed(inv_dir[COORD_BITS-1:LB]);

   assign prod_min = (PW'(pmin_hi_ff) <<< LB) + PW'(pmin_lo_ff);
   assign prod_max = (PW'(pmax_hi_ff) <<< LB) + PW'(pmax_lo_ff);

   always_ff @(posedge clock) begin
      if (adv.diff) begin
         dmin_ff <= DW'(box_min) - DW'(origin);
         dmax_ff <= DW'(box_max) - DW'(origin);
      end
      if (adv.mul) begin
         pmin_lo_ff <= pmin_lo_in;
         pmax_lo_ff <= pmax_lo_in;
         pmin_hi_ff <= pmin_hi_in;
         pmax_hi_ff <= pmax_hi_in;
      end
      if (adv.prod) begin
         t1_ff <= shift_sat(prod_min);
         t2_ff <= shift_sat(prod_max);
      end
      if (adv.sort) begin
         lo_ff <= (t1_ff < t2_ff) ? t1_ff : t2_ff;
         hi_ff <= (t1_ff < t2_ff) ? t2_ff : t1_ff;
      end
   end

   assign t_lo = lo_ff;
   assign t_hi = hi_ff;

endmodule

>>> rtl/ray_box_slab_intersection.sv
// Top level: ray / axis-aligned box slab test, one box per clock unless a held result fills the pipeline.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+---------------------------------------
//  req     | in  | tvalid / tready  | box corners, min x,y,z then max x,y,z
//  rsp     | out | tvalid / tready  | hit, near_distance
//  csr     | in  | APB psel/penable | origin, inv_dir, window (8 registers)
//
//  Flow: one box request enters per clock unless a held result fills every
//  stage; each request passes the offset, product, shift, sort, tree and hit
//  registers in turn. Depth is set by the split multiplier (partial products,
//  then sum/shift/saturate) and the two-level min/max tree before the hit compare.
//  Reset clears every stage valid bit and loads the register defaults
//  (origin 0, inv_dir 1.0, full window).
//  Stalls: each stage loads when it is empty or the stage after it moves, so
//  bubbles are squeezed out and a held result blocks input only once all six
//  stages are full.
module ray_box_slab_intersection import rbsi_pkg::*; #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, zero pad
   input  logic [((6*COORD_BITS+7)/8)*8-1:0] req_tdata,
   // result channel
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // hit, near_distance, zero pad
   output logic [((COORD_BITS+8)/8)*8-1:0] rsp_tdata,
   // configuration port
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [2+$clog2((COORD_BITS>32 ? 64 : 32)/8):0] csr_paddr,
   input  logic [(COORD_BITS>32 ? 64 : 32)-1:0] csr_pwdata,
   output logic [(COORD_BITS>32 ? 64 : 32)-1:0] csr_prdata,
   output logic                         csr_pready
);

   localparam int CSR_DATA_BITS = (COORD_BITS > 32) ? 64 : 32;
   localparam int CSR_ADDR_BITS = 3 + $clog2(CSR_DATA_BITS / 8);
   localparam int RSP_BITS      = ((COORD_BITS + 8) / 8) * 8;
   localparam logic signed [COORD_BITS-1:0] COORD_MAX =
      {1'b0, {(COORD_BITS-1){1'b1}}};

   // ray configuration
   logic signed [COORD_BITS-1:0] origin [NUM_AXES];
   logic signed [COORD_BITS-1:0] inv_dir [NUM_AXES];
   logic signed [COORD_BITS-1:0] window_low, window_high;

   rbsi_csr #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS),
      .DATA_BITS (CSR_DATA_BITS),
      .ADDR_BITS (CSR_ADDR_BITS)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .origin     (origin),
      .inv_dir    (inv_dir),
      .window_low (window_low),
      .window_high(window_high)
   );

   // pipeline control: stage i loads when empty or when stage i+1 moves
   logic [PIPE_STAGES-1:0] valid_ff, valid_in;
   logic [PIPE_STAGES:0]   ready;
   logic [PIPE_STAGES-1:0] adv;
   axis_adv_type           axis_adv;

   always_comb begin
      ready[PIPE_STAGES] = rsp_tready;
      for (int i = PIPE_STAGES - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   assign adv        = ready[PIPE_STAGES-1:0];
   assign req_tready = ready[0];
   assign valid_in   = {valid_ff[PIPE_STAGES-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < PIPE_STAGES; i++) begin
            if (adv[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   assign axis_adv.diff = adv[0];
   assign axis_adv.mul  = adv[1];
   assign axis_adv.prod = adv[2];
   assign axis_adv.sort = adv[3];

   // stages 1-4: one slab unit per axis
   logic signed [COORD_BITS-1:0] t_lo [NUM_AXES];
   logic signed [COORD_BITS-1:0] t_hi [NUM_AXES];

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      rbsi_axis #(
         .COORD_BITS(COORD_BITS),
         .FRAC_BITS (FRAC_BITS)
      ) u_axis (
         .clock  (clock),
         .adv    (axis_adv),
         .box_min($signed(req_tdata[a*COORD_BITS +: COORD_BITS])),
         .box_max($signed(req_tdata[(a+NUM_AXES)*COORD_BITS +: COORD_BITS])),
         .origin (origin[a]),
         .inv_dir(inv_dir[a]),
         .t_lo   (t_lo[a]),
         .t_hi   (t_hi[a])
      );
   end

   // stage 5: near = max of axis entries and window_low, far = min of exits
   // and window_high, as a two-level tree
   logic signed [COORD_BITS-1:0] near_a, near_b, far_a, far_b;
   logic signed [COORD_BITS-1:0] near_ff, far_ff;

   assign near_a = (t_lo[0] > t_lo[1])     ? t_lo[0] : t_lo[1];
   assign near_b = (t_lo[2] > window_low)  ? t_lo[2] : window_low;
   assign far_a  = (t_hi[0] < t_hi[1])     ? t_hi[0] : t_hi[1];
   assign far_b  = (t_hi[2] < window_high) ? t_hi[2] : window_high;

   // stage 6: hit compare into the output register
   logic                         hit_ff;
   logic signed [COORD_BITS-1:0] dist_ff;
   logic                         hit_in;

   assign hit_in = (near_ff <= far_ff);

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         near_ff <= (near_a > near_b) ? near_a : near_b;
         far_ff  <= (far_a < far_b) ? far_a : far_b;
      end
      if (adv[5]) begin
         hit_ff  <= hit_in;
         dist_ff <= hit_in ? near_ff : COORD_MAX;   // miss reports far-away
      end
   end

   assign rsp_tvalid = valid_ff[PIPE_STAGES-1];
   assign rsp_tdata  = RSP_BITS'({dist_ff, hit_ff});

`ifndef SYNTH
   // input stalls only when every stage is full and the output is held
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> ((&valid_ff) && !rsp_tready))
      else $error("request stalled with a free pipeline slot");

   // a miss always carries the most positive distance
   a_miss_dist: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !hit_ff) |-> (dist_ff == COORD_MAX))
      else $error("miss result with a finite distance");

   // a stage that could not move still holds its item next cycle
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (valid_ff != '0) |=> (($past(valid_ff) & ~$past(adv) & ~valid_ff) == '0))
      else $error("stalled pipeline stage lost its item");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (valid_ff == '0))
      else $error("valid bit survived reset");
`endif

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// Testbench for the ray / box slab test: scoreboard, request and result drivers, phases.
module tb;
   import rbsi_pkg::*;

   localparam int COORD = 32;
   localparam int FRAC  = 16;
   // Cycles without any handshake before the run is declared hung. The longest
   // legal quiet stretch is a sender gap, the pipeline, a receiver stall and
   // the pause before a register write.
   localparam int IDLE_LIMIT = 1000;

   typedef logic signed [COORD-1:0] coord_type;
   typedef coord_type box_type [6];   // min x, min y, min z, max x, max y, max z
   typedef struct {
      logic      hit;
      coord_type near_dist;
   } slab_result_type;

   localparam coord_type T_MAX = 32'sh7FFF_FFFF;
   localparam coord_type T_MIN = 32'sh8000_0000;
   localparam coord_type ONE   = 32'sd65536;   // 1.0 in Q16.16

   // Holds a shadow copy of the ray registers and the queue of expected slab
   // results, one per accepted box request.
   class slab_scoreboard;
      coord_type       regs [NUM_REGS];
      slab_result_type outstanding [$];
      int              mismatches;

      function new();
         regs[CSR_ORIGIN_X]    = 0;
         regs[CSR_ORIGIN_Y]    = 0;
         regs[CSR_ORIGIN_Z]    = 0;
         regs[CSR_INV_DIR_X]   = ONE;
         regs[CSR_INV_DIR_Y]   = ONE;
         regs[CSR_INV_DIR_Z]   = ONE;
         regs[CSR_WINDOW_LOW]  = T_MIN;
         regs[CSR_WINDOW_HIGH] = T_MAX;
         mismatches = 0;
      endfunction

      function void write_reg(csr_index_type idx, coord_type value);
         regs[idx] = value;
      endfunction

      // inv * (corner - origin), floored by the fraction shift, saturated
      function coord_type axis_distance(coord_type inv, coord_type corner, coord_type org);
         logic signed [COORD:0]     diff;
         logic signed [2*COORD+1:0] prod;
         diff = $signed({corner[COORD-1], corner}) - $signed({org[COORD-1], org});
         prod = inv * diff;
         prod = prod >>> FRAC;
         if (prod > T_MAX) return T_MAX;
         if (prod < T_MIN) return T_MIN;
         return prod[COORD-1:0];
      endfunction

      function void note_box(box_type b);
         coord_type       near_t, far_t, t1, t2;
         slab_result_type r;
         near_t = T_MIN;
         far_t  = T_MAX;
         for (int a = 0; a < NUM_AXES; a++) begin
            t1 = axis_distance(regs[CSR_INV_DIR_X + a], b[a], regs[CSR_ORIGIN_X + a]);
            t2 = axis_distance(regs[CSR_INV_DIR_X + a], b[a + 3], regs[CSR_ORIGIN_X + a]);
            if (t1 > t2) begin
               if (t2 > near_t) near_t = t2;
               if (t1 < far_t) far_t = t1;
            end else begin
               if (t1 > near_t) near_t = t1;
               if (t2 < far_t) far_t = t2;
            end
         end
         if (regs[CSR_WINDOW_LOW] > near_t) near_t = regs[CSR_WINDOW_LOW];
         if (regs[CSR_WINDOW_HIGH] < far_t) far_t = regs[CSR_WINDOW_HIGH];
         r.hit       = (near_t <= far_t);
         r.near_dist = r.hit ? near_t : T_MAX;
         outstanding = {outstanding, r};
      endfunction

      function void check_result(logic hit, coord_type near_dist);
         slab_result_type e;
         if (outstanding.size() == 0) begin
            $error("result with no box outstanding: hit %0d near_distance %0d",
                   hit, near_dist);
            mismatches++;
            return;
         end
         e = outstanding.pop_front();
         if (hit !== e.hit) begin
            $error("hit: expected %0d, actual %0d", e.hit, hit);
            mismatches++;
         end
         if (near_dist !== e.near_dist) begin
            $error("near_distance: expected %0d, actual %0d", e.near_dist, near_dist);
            mismatches++;
         end
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [191:0]  req_tdata;    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [39:0]   rsp_tdata;    // hit, near_distance, zero pad
   logic          csr_psel;
   logic          csr_penable;
   logic          csr_pwrite;
   logic [4:0]    csr_paddr;
   logic [31:0]   csr_pwdata;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   slab_scoreboard scoreboard = new();
   int             idle_cycles = 0;
   bit             steady_flow = 0;   // when set, neither side inserts idle cycles

   ray_box_slab_intersection #(
      .COORD_BITS (COORD),
      .FRAC_BITS  (FRAC)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Monitor: everything is sampled on the rising edge, while stimulus only
   // moves on the falling edge, so no sample races a drive.
   always @(posedge clock) begin
      box_type accepted;
      bit      busy;
      busy = 0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            for (int i = 0; i < 6; i++) accepted[i] = req_tdata[COORD*i +: COORD];
            scoreboard.note_box(accepted);
            busy = 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            scoreboard.check_result(rsp_tdata[0], rsp_tdata[COORD:1]);
            busy = 1;
         end
         // register copy follows the write at the same edge the block takes it
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            scoreboard.write_reg(csr_index_type'(csr_paddr[4:2]), csr_pwdata);
            busy = 1;
         end
      end
      idle_cycles = busy ? 0 : idle_cycles + 1;
   end

   // Watchdog: a hung handshake ends the run.
   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   // Result side: before each result, insert a random stall unless the phase
   // runs at full rate.
   initial begin
      int stall;
      rsp_tready = 0;
      @(negedge clock);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_tready = 0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         @(negedge clock);
      end
   end

   function automatic coord_type span(int bits);
      longint r;
      r = $urandom_range(0, 2 ** (bits + 1));
      return coord_type'(r - 2 ** bits);
   endfunction

   // Full-range word, biased toward the extremes.
   function automatic coord_type any_word();
      unique case ($urandom_range(0, 7))
         0:       return T_MIN;
         1:       return T_MAX;
         2:       return 0;
         3:       return -1;
         default: return $urandom();
      endcase
   endfunction

   function automatic box_type make_box(coord_type x0, coord_type y0, coord_type z0,
                                        coord_type x1, coord_type y1, coord_type z1);
      box_type b;
      b[0] = x0; b[1] = y0; b[2] = z0;
      b[3] = x1; b[4] = y1; b[5] = z1;
      return b;
   endfunction

   function automatic box_type noise_box();
      box_type b;
      for (int i = 0; i < 6; i++) b[i] = any_word();
      return b;
   endfunction

   // Box placed around a point on the current ray, so most of these hit. A few
   // are pushed off the ray on one or more axes or have their corners swapped.
   function automatic box_type aimed_box();
      box_type   b;
      longint    t, dir, pt, lo, hi, wl, off;
      coord_type inv;
      wl = scoreboard.regs[CSR_WINDOW_LOW];
      if (wl == T_MIN || $urandom_range(0, 1)) t = span(20);
      else t = wl + $urandom_range(0, 1 << 20) - (1 << 16);
      for (int a = 0; a < NUM_AXES; a++) begin
         inv = scoreboard.regs[CSR_INV_DIR_X + a];
         pt  = scoreboard.regs[CSR_ORIGIN_X + a];
         if (inv != 0) begin
            dir = (longint'(1) <<< 32) / longint'(inv);
            pt  = pt + ((t * dir) >>> FRAC);
         end
         lo = pt - $urandom_range(0, 1 << $urandom_range(2, 20));
         hi = pt + $urandom_range(0, 1 << $urandom_range(2, 20));
         if ($urandom_range(0, 5) == 0) begin
            off = span(24);
            lo += off;
            hi += off;
         end
         if ($urandom_range(0, 7) == 0) begin
            b[a]     = coord_type'(hi);
            b[a + 3] = coord_type'(lo);
         end else begin
            b[a]     = coord_type'(lo);
            b[a + 3] = coord_type'(hi);
         end
      end
      return b;
   endfunction

   // Two-phase register write: setup cycle, then access until pready.
   task automatic csr_write(csr_index_type idx, coord_type value);
      csr_psel    = 1;
      csr_penable = 0;
      csr_pwrite  = 1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      @(negedge clock);
      csr_psel    = 0;
      csr_penable = 0;
   endtask

   task automatic load_ray(coord_type ox, coord_type oy, coord_type oz,
                           coord_type ix, coord_type iy, coord_type iz,
                           coord_type wl, coord_type wh);
      csr_write(CSR_ORIGIN_X, ox);
      csr_write(CSR_ORIGIN_Y, oy);
      csr_write(CSR_ORIGIN_Z, oz);
      csr_write(CSR_INV_DIR_X, ix);
      csr_write(CSR_INV_DIR_Y, iy);
      csr_write(CSR_INV_DIR_Z, iz);
      csr_write(CSR_WINDOW_LOW, wl);
      csr_write(CSR_WINDOW_HIGH, wh);
   endtask

   // Ray with modest origin and reciprocal (sometimes a zero axis), and either
   // the full window or a segment that now and then comes out inverted.
   task automatic aimed_ray();
      coord_type v [8];
      longint    mag;
      for (int a = 0; a < NUM_AXES; a++) begin
         v[a] = span(20);
         mag  = $urandom_range(1 << 12, 1 << 20);
         if ($urandom_range(0, 9) == 0) v[3 + a] = 0;
         else v[3 + a] = $urandom_range(0, 1) ? coord_type'(mag) : coord_type'(-mag);
      end
      if ($urandom_range(0, 1)) begin
         v[6] = T_MIN;
         v[7] = T_MAX;
      end else begin
         v[6] = span(22);
         v[7] = coord_type'(longint'(v[6]) + $urandom_range(0, 1 << 23) - (1 << 19));
      end
      load_ray(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
   endtask

   // Sends one box request after a random gap, then holds it until taken.
   // Entered and left just after a falling edge.
   task automatic send_box(box_type b);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid = 0;
         repeat (gap) @(negedge clock);
      end
      for (int i = 0; i < 6; i++) req_tdata[COORD*i +: COORD] = b[i];
      req_tvalid = 1;
      do @(posedge clock); while (req_tready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic random_boxes(int n, int aimed_pct);
      repeat (n) begin
         if ($urandom_range(0, 99) < aimed_pct) send_box(aimed_box());
         else send_box(noise_box());
      end
   endtask

   // Registers may only change with the pipeline empty: wait for every
   // outstanding result, then give the stages time to settle.
   task automatic drain();
      req_tvalid = 0;
      while (scoreboard.outstanding.size() != 0) @(negedge clock);
      repeat (PIPE_STAGES + 2) @(negedge clock);
      steady_flow = ($urandom_range(0, 3) == 0);
   endtask

   initial begin
      reset       = 1;
      req_tvalid  = 0;
      req_tdata   = '0;
      csr_psel    = 0;
      csr_penable = 0;
      csr_pwrite  = 0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Reset ray: origin 0, unit reciprocal, full window, so each slab
      // distance equals the coordinate itself.
      send_box(make_box(-ONE, -ONE, -ONE, ONE, ONE, ONE));             // origin inside
      send_box(make_box(2 * ONE, 2 * ONE, 2 * ONE, 3 * ONE, 3 * ONE, 3 * ONE));
      send_box(make_box(ONE, 3 * ONE, ONE, 2 * ONE, 4 * ONE, 2 * ONE)); // slabs disjoint
      send_box(make_box(3 * ONE, 3 * ONE, 3 * ONE, 2 * ONE, 2 * ONE, 2 * ONE)); // swapped
      send_box(make_box(T_MIN, T_MIN, T_MIN, T_MAX, T_MAX, T_MAX));
      send_box(make_box(T_MAX, T_MAX, T_MAX, T_MAX, T_MAX, T_MAX));
      send_box(make_box(T_MIN, T_MIN, T_MIN, T_MIN, T_MIN, T_MIN));
      send_box(make_box(0, 0, 0, 0, 0, 0));
      send_box(make_box(T_MAX, T_MAX, T_MAX, T_MIN, T_MIN, T_MIN));
      send_box(make_box(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                        32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555));
      send_box(make_box(-5 * ONE, -ONE, -ONE, -4 * ONE, ONE, ONE));
      random_boxes(60, 85);
      drain();

      // Positive saturation on x and y, zero reciprocal on z.
      load_ray(T_MIN, T_MAX, 0, T_MAX, T_MIN, 0, T_MIN, T_MAX);
      send_box(make_box(T_MAX, T_MIN, ONE, T_MIN, T_MAX, -ONE));
      send_box(make_box(T_MIN, T_MAX, 0, T_MAX, T_MIN, 0));
      random_boxes(30, 0);
      drain();

      // Negative saturation on x and y; z reciprocal of -1 lsb exercises the
      // round-toward-minus-infinity shift.
      load_ray(T_MAX, T_MIN, 0, T_MAX, T_MIN, -1, T_MIN, T_MAX);
      send_box(make_box(T_MIN, T_MAX, 1, T_MAX, T_MIN, 3));
      send_box(make_box(0, 0, -1, 0, 0, 65537));
      random_boxes(30, 0);
      drain();

      // Inverted window: every box misses.
      load_ray(0, 0, 0, ONE, ONE, ONE, ONE, -ONE);
      send_box(make_box(-ONE, -ONE, -ONE, ONE, ONE, ONE));
      random_boxes(20, 80);
      drain();

      // Window collapsed to the single point 0.
      load_ray(0, 0, 0, ONE, ONE, ONE, 0, 0);
      send_box(make_box(-ONE, -ONE, -ONE, ONE, ONE, ONE));
      send_box(make_box(ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE));
      random_boxes(20, 80);
      drain();

      // Random rays: mostly well-aimed rays and boxes, a few full-range ones.
      for (int p = 0; p < 10; p++) begin
         if (p % 5 == 4) begin
            load_ray(any_word(), any_word(), any_word(), any_word(), any_word(),
                     any_word(), any_word(), any_word());
            random_boxes(50, 30);
         end else begin
            aimed_ray();
            random_boxes(50, 80);
         end
         drain();
      end

      if (scoreboard.mismatches == 0 && scoreboard.outstanding.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
